### src/pfc_pkg.sv
package pfc_pkg;

  localparam int unsigned HdrBytes  = 9;
  localparam int unsigned CrcBytes  = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0] TYPE_DATA = 8'd1;
  localparam logic [7:0] TYPE_ACK  = 8'd2;
  localparam logic [7:0] DATA_NTX  = 8'd1;

  // Configuration register indexes
  localparam logic [2:0] REG_DEST_ADDRESS    = 3'd0;
  localparam logic [2:0] REG_OWN_ADDRESS     = 3'd1;
  localparam logic [2:0] REG_RESERVED_ONE    = 3'd2;
  localparam logic [2:0] REG_RESERVED_TWO    = 3'd3;
  localparam logic [2:0] REG_MODULATION_CODE = 3'd4;

  // Header byte positions
  localparam logic [3:0] HB_TYPE  = 4'd0;
  localparam logic [3:0] HB_INDEX = 4'd1;
  localparam logic [3:0] HB_DEST  = 4'd2;
  localparam logic [3:0] HB_SRC   = 4'd3;
  localparam logic [3:0] HB_NTX   = 4'd4;
  localparam logic [3:0] HB_RES1  = 4'd5;
  localparam logic [3:0] HB_RES2  = 4'd6;
  localparam logic [3:0] HB_LEN   = 4'd7;
  localparam logic [3:0] HB_MOD   = 4'd8;

  localparam logic [3:0] HDR_LAST = 4'(HdrBytes - 1);
  localparam logic [3:0] CRC_LAST = 4'(CrcBytes - 1);

  typedef struct packed {
    logic [7:0] dest_address;
    logic [7:0] own_address;
    logic [7:0] reserved_one;
    logic [7:0] reserved_two;
    logic [7:0] modulation_code;
  } cfg_t;

  // One job for the back end: which sections to emit and the header fields
  typedef struct packed {
    logic       is_ack;
    logic       has_hdr;
    logic       has_data;
    logic       has_crc;
    logic [7:0] data_byte;
    logic [7:0] frm_idx;
    logic [7:0] peer_address;
    logic [7:0] tx_count;
    logic [7:0] pay_len;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_START,
    ST_HDR,
    ST_DATA,
    ST_CRC
  } phase_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/pfc_front.sv
module pfc_front import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic       in_first,
  input  logic       in_last,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_frm_idx,
  input  logic [7:0] in_peer_address,
  input  logic [7:0] in_tx_count,
  input  logic [7:0] in_pay_len,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       fifo_full
);

  logic in_frame_r, in_frame_nxt;
  logic accept;
  logic drop;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  // A payload word outside an open frame gives nothing
  assign drop = !in_kind && !in_first && !in_frame_r;
  assign push = accept && !drop;

  // Classify the word into a job
  always_comb begin
    push_cmd.is_ack       = in_kind;
    push_cmd.has_hdr      = in_kind || in_first;
    push_cmd.has_data     = !in_kind;
    push_cmd.has_crc      = in_kind || in_last;
    push_cmd.data_byte    = in_data_byte;
    push_cmd.frm_idx      = in_frm_idx;
    push_cmd.peer_address = in_peer_address;
    push_cmd.tx_count     = in_tx_count;
    push_cmd.pay_len      = in_pay_len;
  end

  // Frame-open tracking
  always_comb begin
    in_frame_nxt = in_frame_r;
    if (accept) begin
      if (in_kind) begin
        in_frame_nxt = 1'b0;
      end else if (in_first || in_frame_r) begin
        in_frame_nxt = !in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

### src/pfc_fifo.sv
module pfc_fifo import pfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              mem_r [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FifoAw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FifoAw:0]   count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == (FifoAw+1)'(FifoDepth));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/pfc_back.sv
module pfc_back import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_frame,
  output logic       out_run_last
);

  phase_t      state_r, state_nxt;
  phase_t      phase;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        advance;
  logic        byte_last;
  logic        byte_eof;
  logic [7:0]  byte_val;
  logic [7:0]  hdr_byte;
  logic [31:0] crc_out;
  logic [31:0] crc_base;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_eof_r;
  logic       out_last_r;

  assign advance = head_valid && (!out_valid_r || out_ready);
  assign pop     = advance && byte_last;

  // Effective phase: a fresh job starts at its first section
  always_comb begin
    phase = state_r;
    if (state_r == ST_START) begin
      if (head_cmd.has_hdr) begin
        phase = ST_HDR;
      end else if (head_cmd.has_data) begin
        phase = ST_DATA;
      end else begin
        phase = ST_CRC;
      end
    end
  end

  // Header byte select
  always_comb begin
    case (idx_r)
      HB_TYPE:  hdr_byte = head_cmd.is_ack ? TYPE_ACK : TYPE_DATA;
      HB_INDEX: hdr_byte = head_cmd.frm_idx;
      HB_DEST:  hdr_byte = head_cmd.is_ack ? head_cmd.peer_address : cfg.dest_address;
      HB_SRC:   hdr_byte = cfg.own_address;
      HB_NTX:   hdr_byte = head_cmd.is_ack ? head_cmd.tx_count : DATA_NTX;
      HB_RES1:  hdr_byte = cfg.reserved_one;
      HB_RES2:  hdr_byte = cfg.reserved_two;
      HB_LEN:   hdr_byte = head_cmd.is_ack ? 8'd0 : head_cmd.pay_len;
      HB_MOD:   hdr_byte = cfg.modulation_code;
      default:  hdr_byte = 8'd0;
    endcase
  end

  assign crc_out = ~crc_r;

  // Output byte, flags and CRC update
  always_comb begin
    byte_val  = 8'd0;
    byte_last = 1'b0;
    byte_eof  = 1'b0;
    crc_base  = crc_r;
    crc_nxt   = crc_r;
    case (phase)
      ST_HDR: begin
        byte_val  = hdr_byte;
        byte_last = (idx_r == HDR_LAST) && !head_cmd.has_data && !head_cmd.has_crc;
        crc_base  = (idx_r == HB_TYPE) ? CRC_INIT : crc_r;
        crc_nxt   = crc_byte(crc_base, hdr_byte);
      end
      ST_DATA: begin
        byte_val  = head_cmd.data_byte;
        byte_last = !head_cmd.has_crc;
        crc_nxt   = crc_byte(crc_r, head_cmd.data_byte);
      end
      ST_CRC: begin
        byte_val  = crc_out[{idx_r[1:0], 3'b000} +: 8];
        byte_last = (idx_r == CRC_LAST);
        byte_eof  = (idx_r == CRC_LAST);
        if (idx_r == CRC_LAST) begin
          crc_nxt = CRC_INIT;
        end
      end
      default: begin
        byte_val = 8'd0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    if (advance) begin
      case (phase)
        ST_HDR: begin
          if (idx_r != HDR_LAST) begin
            state_nxt = ST_HDR;
            idx_nxt   = idx_r + 4'd1;
          end else begin
            idx_nxt = 4'd0;
            if (head_cmd.has_data) begin
              state_nxt = ST_DATA;
            end else if (head_cmd.has_crc) begin
              state_nxt = ST_CRC;
            end else begin
              state_nxt = ST_START;
            end
          end
        end
        ST_DATA: begin
          idx_nxt   = 4'd0;
          state_nxt = head_cmd.has_crc ? ST_CRC : ST_START;
        end
        ST_CRC: begin
          if (idx_r != CRC_LAST) begin
            state_nxt = ST_CRC;
            idx_nxt   = idx_r + 4'd1;
          end else begin
            state_nxt = ST_START;
            idx_nxt   = 4'd0;
          end
        end
        default: begin
          state_nxt = ST_START;
          idx_nxt   = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      idx_r   <= 4'd0;
      crc_r   <= CRC_INIT;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (advance) begin
        crc_r <= crc_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= byte_val;
      out_eof_r  <= byte_eof;
      out_last_r <= byte_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_end_of_frame = out_eof_r;
  assign out_run_last     = out_last_r;

endmodule

### src/packet_framer_crc32.sv
// Packet framer with CRC-32.
// Input channel (in_valid/in_ready): one word per cycle while the queue is
// not full, either a payload byte of a data frame (with first/last markers)
// or an ack request. The first payload byte is preceded by a 9-byte header;
// the last is followed by the CRC-32 of header and payload, low byte first.
// An ack request yields a 9-byte header and its CRC (13 bytes). Payload
// words outside an open frame are dropped.
// Output channel (out_valid/out_ready): one frame byte per cycle while
// out_ready is high and jobs are queued, with end-of-frame on the final CRC
// byte and run_last on the final byte caused by an input word.
// Throughput: one output byte per cycle while out_ready is high. A payload
// word in mid-frame yields one byte (plus the CRC if last), a first word 10
// bytes, a first+last word 14 and an ack 13, set by the byte sequencer in
// the back end. An accepted word is written into the job queue, and its
// first byte then into the output register. A 4-deep job queue decouples the
// input side, so input keeps flowing while the output stalls until it fills.
// Reset clears the queue, open-frame flag, CRC, config registers and out_valid.
// Configuration (cfg_valid/cfg_ready) is always ready; write only while idle.
module packet_framer_crc32 import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic       in_first,
  input  logic       in_last,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_frm_idx,
  input  logic [7:0] in_peer_address,
  input  logic [7:0] in_tx_count,
  input  logic [7:0] in_pay_len,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_frame,
  output logic       out_run_last
);

  cfg_t cfg_r;
  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEST_ADDRESS:    cfg_r.dest_address    <= cfg_data;
        REG_OWN_ADDRESS:     cfg_r.own_address     <= cfg_data;
        REG_RESERVED_ONE:    cfg_r.reserved_one    <= cfg_data;
        REG_RESERVED_TWO:    cfg_r.reserved_two    <= cfg_data;
        REG_MODULATION_CODE: cfg_r.modulation_code <= cfg_data;
        default: ;
      endcase
    end
  end

  pfc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_first        (in_first),
    .in_last         (in_last),
    .in_data_byte    (in_data_byte),
    .in_frm_idx      (in_frm_idx),
    .in_peer_address (in_peer_address),
    .in_tx_count     (in_tx_count),
    .in_pay_len      (in_pay_len),
    .push            (push),
    .push_cmd        (push_cmd),
    .fifo_full       (fifo_full)
  );

  pfc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head_valid       (head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_end_of_frame (out_end_of_frame),
    .out_run_last     (out_run_last)
  );

endmodule

### tb/packet_framer_crc32_check.sv
module packet_framer_crc32_check import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_kind,
  input  logic       in_first,
  input  logic       in_last,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_frm_idx,
  input  logic [7:0] in_peer_address,
  input  logic [7:0] in_tx_count,
  input  logic [7:0] in_pay_len,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_end_of_frame,
  input  logic       out_run_last,
  output int         fail_count,
  output int         pending,
  output int         bytes_checked,
  output int         frames_closed
);

  typedef struct packed {
    logic [7:0] value;
    logic       eof;
    logic       run_last;
  } frame_byte_t;

  // Frame bytes still owed by the block, oldest first
  frame_byte_t expected_bytes[$];

  cfg_t        regs;
  logic [31:0] crc_acc;
  logic        frame_open;

  // Reflected CRC-32, one bit of the byte at a time
  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = {1'b0, r[31:1]} ^ CRC_POLY;
      end else begin
        r = {1'b0, r[31:1]};
      end
    end
    return r;
  endfunction

  task automatic emit(input logic [7:0] v, input logic eof, input logic feed);
    frame_byte_t e;
    e.value    = v;
    e.eof      = eof;
    e.run_last = 1'b0;
    if (feed) crc_acc = crc32_fold(crc_acc, v);
    expected_bytes.push_back(e);
  endtask

  task automatic emit_header(input logic [7:0] type_code, input logic [7:0] idx,
                             input logic [7:0] dst, input logic [7:0] ntx,
                             input logic [7:0] plen);
    emit(type_code, 1'b0, 1'b1);
    emit(idx, 1'b0, 1'b1);
    emit(dst, 1'b0, 1'b1);
    emit(regs.own_address, 1'b0, 1'b1);
    emit(ntx, 1'b0, 1'b1);
    emit(regs.reserved_one, 1'b0, 1'b1);
    emit(regs.reserved_two, 1'b0, 1'b1);
    emit(plen, 1'b0, 1'b1);
    emit(regs.modulation_code, 1'b0, 1'b1);
  endtask

  // CRC goes out low byte first, then the accumulator restarts
  task automatic emit_crc();
    logic [31:0] c;
    c = ~crc_acc;
    for (int k = 0; k < 4; k++) begin
      emit(c[8*k +: 8], k == 3, 1'b0);
    end
    crc_acc = CRC_INIT;
  endtask

  // Expected frame bytes for the word accepted on the input channel
  task automatic frame_input_word();
    int          count_at_start;
    frame_byte_t tail;
    count_at_start = expected_bytes.size();
    if (in_kind) begin
      // ack drops any open data frame and goes out whole
      frame_open = 1'b0;
      crc_acc    = CRC_INIT;
      emit_header(TYPE_ACK, in_frm_idx, in_peer_address, in_tx_count, 8'd0);
      emit_crc();
    end else begin
      if (in_first) begin
        crc_acc    = CRC_INIT;
        frame_open = 1'b1;
        emit_header(TYPE_DATA, in_frm_idx, regs.dest_address, DATA_NTX, in_pay_len);
      end
      if (frame_open) begin
        emit(in_data_byte, 1'b0, 1'b1);
        if (in_last) begin
          emit_crc();
          frame_open = 1'b0;
        end
      end
    end
    if (expected_bytes.size() > count_at_start) begin
      tail          = expected_bytes.pop_back();
      tail.run_last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endtask

  task automatic compare_output();
    frame_byte_t e;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected output byte %02h (eof %0b run_last %0b)",
               $time, out_byte, out_end_of_frame, out_run_last);
      fail_count++;
    end else begin
      e = expected_bytes.pop_front();
      bytes_checked++;
      if (out_byte !== e.value) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, e.value, out_byte);
        fail_count++;
      end
      if (out_end_of_frame !== e.eof) begin
        $display("%0t: out_end_of_frame expected %0b actual %0b",
                 $time, e.eof, out_end_of_frame);
        fail_count++;
      end
      if (out_run_last !== e.run_last) begin
        $display("%0t: out_run_last expected %0b actual %0b",
                 $time, e.run_last, out_run_last);
        fail_count++;
      end
      if (e.eof) frames_closed++;
    end
  endtask

  // Watch all three channels at every edge
  always @(posedge clk) begin
    if (!rst_n) begin
      regs       = '0;
      crc_acc    = CRC_INIT;
      frame_open = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEST_ADDRESS:    regs.dest_address    = cfg_data;
          REG_OWN_ADDRESS:     regs.own_address     = cfg_data;
          REG_RESERVED_ONE:    regs.reserved_one    = cfg_data;
          REG_RESERVED_TWO:    regs.reserved_two    = cfg_data;
          REG_MODULATION_CODE: regs.modulation_code = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) frame_input_word();
      if (out_valid && out_ready) compare_output();
    end
    pending <= expected_bytes.size();
  end

endmodule

### tb/packet_framer_crc32_test.sv
module packet_framer_crc32_test import pfc_pkg::*; ();

  localparam int HoldCycles   = 300;
  localparam int StallLimit   = 3000;
  localparam int SettleCycles = 16;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = 1'b0;
  logic       in_first = 1'b0;
  logic       in_last = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic [7:0] in_frm_idx = '0;
  logic [7:0] in_peer_address = '0;
  logic [7:0] in_tx_count = '0;
  logic [7:0] in_pay_len = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_end_of_frame;
  logic       out_run_last;

  int fail_count;
  int pending;
  int bytes_checked;
  int frames_closed;

  // Stimulus bookkeeping
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit open_model = 1'b0;
  int gap_pct = 35;
  int words_sent = 0;
  int acks_sent = 0;
  int dropped = 0;
  int counted_words = 0;
  int settings_applied = 0;
  int holds_done = 0;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  packet_framer_crc32 i_dut (.*);

  packet_framer_crc32_check i_check (.*);

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  // Offer one word, with an optional idle burst ahead of it
  task automatic send_word(input logic kind, input logic first, input logic last,
                           input logic [7:0] data, input logic [7:0] idx,
                           input logic [7:0] peer, input logic [7:0] ntx,
                           input logic [7:0] plen);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_first        <= first;
    in_last         <= last;
    in_data_byte    <= data;
    in_frm_idx      <= idx;
    in_peer_address <= peer;
    in_tx_count     <= ntx;
    in_pay_len      <= plen;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (kind) begin
      acks_sent++;
      counted_words++;
      open_model = 1'b0;
    end else begin
      if (first) open_model = 1'b1;
      if (open_model) counted_words++;
      else dropped++;
      if (open_model && last) open_model = 1'b0;
    end
  endtask

  task automatic send_frame(input int len, input bit closes, input bit true_len);
    logic [7:0] plen;
    plen = true_len ? 8'(len) : rand8();
    for (int i = 0; i < len; i++) begin
      send_word(1'b0, i == 0, closes && (i == len - 1), rand8(), rand8(), rand8(),
                rand8(), plen);
    end
  endtask

  // Let every owed byte come out, then give the block time to settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_setting(input logic [7:0] dst, input logic [7:0] own,
                               input logic [7:0] res1, input logic [7:0] res2,
                               input logic [7:0] modc);
    write_reg(REG_DEST_ADDRESS, dst);
    write_reg(REG_OWN_ADDRESS, own);
    write_reg(REG_RESERVED_ONE, res1);
    write_reg(REG_RESERVED_TWO, res2);
    write_reg(REG_MODULATION_CODE, modc);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Mostly well-formed frames; acks, abandoned frames, stray bytes and noise
  task automatic random_phase(input int target);
    int goal;
    int r;
    int len;
    goal = counted_words + target;
    while (counted_words < goal) begin
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
        send_frame(len, 1'b1, $urandom_range(0, 3) != 0);
      end else if (r < 70) begin
        send_word(1'b1, 1'($urandom), 1'($urandom), rand8(), rand8(), rand8(), rand8(),
                  rand8());
      end else if (r < 82) begin
        send_frame($urandom_range(1, 3), 1'b0, 1'b1);
      end else if (r < 92) begin
        if (open_model) begin
          send_word(1'b1, 1'b0, 1'b0, rand8(), rand8(), rand8(), rand8(), rand8());
        end else begin
          send_word(1'b0, 1'b0, 1'($urandom), rand8(), rand8(), rand8(), rand8(), rand8());
        end
      end else begin
        send_word(1'($urandom), 1'($urandom), 1'($urandom), rand8(), rand8(), rand8(),
                  rand8(), rand8());
      end
    end
  endtask

  // Receiver: random ready bursts, steady stretches, and the long hold-off
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat (32) @(posedge clk);
      end else begin
        out_ready <= 1'($urandom);
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: watchdog: no word moved for %0d cycles", $time, StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words with the registers at their reset values
    send_word(1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // single-byte frame
    send_word(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // ack, flags ignored
    send_word(1'b0, 1'b0, 1'b0, 8'hAA, 8'h55, 8'h55, 8'h55, 8'h55);  // stray byte
    send_word(1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // stray last byte
    send_word(1'b0, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(1'b0, 1'b0, 1'b0, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(1'b0, 1'b1, 1'b0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h03);  // restart mid-frame
    send_word(1'b0, 1'b0, 1'b0, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08);
    send_word(1'b0, 1'b0, 1'b1, 8'h01, 8'h10, 8'h20, 8'h40, 8'h80);
    send_word(1'b0, 1'b1, 1'b0, 8'h33, 8'h07, 8'h00, 8'h00, 8'h02);
    send_word(1'b1, 1'b0, 1'b0, 8'h00, 8'h07, 8'h40, 8'h03, 8'h00);  // ack in open frame
    send_word(1'b0, 1'b0, 1'b1, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55);  // dropped after ack
    send_word(1'b1, 1'b0, 1'b1, 8'hC3, 8'h80, 8'h01, 8'h00, 8'hFF);
    drain();

    write_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(1'b0, 1'b1, 1'b0, 8'h5A, 8'hC3, 8'h3C, 8'hA5, 8'h02);
    send_word(1'b0, 1'b0, 1'b1, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h02);
    drain();

    write_setting(rand8(), rand8(), rand8(), rand8(), rand8());
    random_phase(40);
    drain();

    // Long receiver hold-off while a long frame keeps coming
    write_setting(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
    hold_req = 1'b1;
    gap_pct  = 0;
    send_frame(24, 1'b1, 1'b1);
    random_phase(35);
    drain();

    write_setting(rand8(), rand8(), rand8(), rand8(), rand8());
    random_phase(40);
    drain();

    // Final stretch without idling on either side
    write_setting(rand8(), rand8(), rand8(), rand8(), rand8());
    calm = 1'b1;
    random_phase(35);
    drain();

    $display("Run covered %0d input words (%0d acks, %0d dropped), %0d register settings,",
             words_sent, acks_sent, dropped, settings_applied);
    $display("  %0d frame bytes checked in %0d closed frames, %0d receiver hold-offs.",
             bytes_checked, frames_closed, holds_done);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
